[rtl/rlc_pkg.sv]
// Shared types and constants of the region label compaction block.
// Holds the item structs, command codes and default sizes; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rlc_pkg;

   localparam int LABEL_W = 12;
   localparam int OUT_W = 13;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int DEFAULT_MAX_LABELS = 4096;
   localparam int DEFAULT_COUNT_BITS = 24;

   localparam logic [1:0] CMD_COUNT = 2'd0;
   localparam logic [1:0] CMD_RENUMBER = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;
   localparam logic [1:0] CMD_CLEAR = 2'd3;

   localparam logic CSR_IDX_HIGHEST_LABEL = 1'b0;
   localparam logic [LABEL_W-1:0] HIGHEST_LABEL_RESET = 12'hFFF;
   localparam logic [OUT_W-1:0] OUT_MAX = 13'h1FFF;

   typedef struct packed {
      logic [1:0] cmd;
      logic [LABEL_W-1:0] label;
      logic label_valid;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] new_label;
      logic [OUT_W-1:0] distinct_labels;
      logic label_out_of_range;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/rlc_table_mem.sv]
// Label table memory: one synchronous write port and one registered read port,
// with a bypass of the write made at the same edge as the read. Uses no package items.
`timescale 1ns / 1ps
`default_nettype none

module rlc_table_mem #(
   parameter int MAX_LABELS = 4096,
   parameter int COUNT_BITS = 24,
   localparam int ADDR_W = $clog2(MAX_LABELS)
) (
   input wire logic clock,
   input wire logic [ADDR_W-1:0] rd_addr,
   output logic [COUNT_BITS-1:0] rd_data,
   input wire logic wr_en,
   input wire logic [ADDR_W-1:0] wr_addr,
   input wire logic [COUNT_BITS-1:0] wr_data
);

   logic [COUNT_BITS-1:0] mem [MAX_LABELS];
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr_ff;
   logic last_wr_en_ff;
   logic [ADDR_W-1:0] last_wr_addr_ff;
   logic [COUNT_BITS-1:0] last_wr_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
      rd_addr_ff <= rd_addr;
      last_wr_en_ff <= wr_en;
      last_wr_addr_ff <= wr_addr;
      last_wr_data_ff <= wr_data;
   end

   assign rd_data = (last_wr_en_ff && (last_wr_addr_ff == rd_addr_ff)) ?
                    last_wr_data_ff : rd_data_ff;

endmodule

`default_nettype wire

[rtl/region_label_compaction.sv]
// Top level of the region label compaction block: command decode, count pipeline,
// renumber walk, clearing sweep and register port. Uses rlc_pkg and rlc_table_mem.
//
// Count and lookup items are taken one per cycle while busy is low; their result is
// registered in the s1 stage and then in the response register. A count and a
// following item on the same label are bypassed around the table memory. A renumber
// item keeps busy high while it walks labels 0 to min(highest_label, MAX_LABELS - 1),
// one table read per label, and its result appears as busy falls.
// A clear item keeps busy high, one table write per entry. After reset the same
// clearing pass runs with busy high and gives no result. Every result is shown for
// exactly one cycle on rsp_strobe and must be taken then: the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module region_label_compaction #(
   parameter int MAX_LABELS = rlc_pkg::DEFAULT_MAX_LABELS,
   parameter int COUNT_BITS = rlc_pkg::DEFAULT_COUNT_BITS
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire rlc_pkg::req_type req_item,
   output logic rsp_strobe,
   output rlc_pkg::rsp_type rsp_item,
   input wire logic psel,
   input wire logic penable,
   input wire logic pwrite,
   input wire logic [rlc_pkg::CSR_ADDR_W-1:0] paddr,
   input wire logic [rlc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [rlc_pkg::CSR_DATA_W-1:0] prdata,
   output logic pready
);

   localparam int ADDR_W = $clog2(MAX_LABELS);
   localparam int LW = rlc_pkg::LABEL_W;
   localparam int OW = rlc_pkg::OUT_W;
   localparam logic [LW-1:0] LAST_CAP =
      (MAX_LABELS > (1 << LW)) ? {LW{1'b1}} : LW'(MAX_LABELS - 1);
   localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(MAX_LABELS - 1);
   localparam logic [COUNT_BITS-1:0] ENTRY_MAX = {COUNT_BITS{1'b1}};

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CLEAR = 2'd1;
   localparam logic [1:0] ST_WALK = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [LW-1:0] highest_ff, highest_in;

   logic s1_valid_ff, s1_valid_in;
   logic s1_lookup_ff, s1_lookup_in;
   logic s1_oor_ff, s1_oor_in;
   logic s1_inc_ff, s1_inc_in;
   logic [ADDR_W-1:0] s1_addr_ff, s1_addr_in;

   logic [LW-1:0] walk_addr_ff, walk_addr_in;
   logic [LW-1:0] walk_last_ff, walk_last_in;
   logic walk_pend_ff, walk_pend_in;
   logic [ADDR_W-1:0] walk_rd_addr_ff, walk_rd_addr_in;
   logic [OW-1:0] next_ff, next_in;

   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic clr_rsp_ff, clr_rsp_in;

   logic rsp_valid_ff, rsp_valid_in;
   rlc_pkg::rsp_type rsp_ff, rsp_in;

   logic accept;
   logic req_in_range;
   logic csr_write;
   logic [ADDR_W-1:0] rd_addr;
   logic [COUNT_BITS-1:0] rd_data;
   logic wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [COUNT_BITS-1:0] wr_data;
   logic [OW-1:0] next_hit;
   logic [OW-1:0] entry_sat;

   rlc_table_mem #(
      .MAX_LABELS(MAX_LABELS),
      .COUNT_BITS(COUNT_BITS)
   ) u_table (
      .clock(clock),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

   assign busy = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign req_in_range = (req_item.label <= highest_ff) &&
                         (32'(req_item.label) < 32'(MAX_LABELS));
   assign csr_write = psel && penable && pwrite && pready;
   assign pready = 1'b1;
   assign prdata = (paddr[2] == rlc_pkg::CSR_IDX_HIGHEST_LABEL) ?
                   rlc_pkg::CSR_DATA_W'(highest_ff) : '0;
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item = rsp_ff;

   assign next_hit = next_ff + OW'(rd_data != '0);
   assign entry_sat = (rd_data > COUNT_BITS'(rlc_pkg::OUT_MAX)) ?
                      rlc_pkg::OUT_MAX : rd_data[OW-1:0];

   always_comb begin
      state_in = state_ff;
      highest_in = highest_ff;
      s1_valid_in = 1'b0;
      s1_lookup_in = s1_lookup_ff;
      s1_oor_in = s1_oor_ff;
      s1_inc_in = s1_inc_ff;
      s1_addr_in = s1_addr_ff;
      walk_addr_in = walk_addr_ff;
      walk_last_in = walk_last_ff;
      walk_pend_in = 1'b0;
      walk_rd_addr_in = walk_rd_addr_ff;
      next_in = next_ff;
      clr_addr_in = clr_addr_ff;
      clr_rsp_in = clr_rsp_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      rd_addr = ADDR_W'(req_item.label);
      wr_en = 1'b0;
      wr_addr = s1_addr_ff;
      wr_data = rd_data + COUNT_BITS'(1);

      if (csr_write && (paddr[2] == rlc_pkg::CSR_IDX_HIGHEST_LABEL)) begin
         highest_in = pwdata[LW-1:0];
      end

      if (s1_valid_ff) begin
         wr_en = !s1_lookup_ff && !s1_oor_ff && s1_inc_ff && (rd_data != ENTRY_MAX);
         rsp_valid_in = 1'b1;
         rsp_in.new_label = (s1_lookup_ff && !s1_oor_ff) ? entry_sat : '0;
         rsp_in.distinct_labels = '0;
         rsp_in.label_out_of_range = s1_oor_ff;
      end

      if (walk_pend_ff) begin
         wr_en = (rd_data != '0);
         wr_addr = walk_rd_addr_ff;
         wr_data = COUNT_BITS'(next_hit);
         next_in = next_hit;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_item.cmd)
                  rlc_pkg::CMD_COUNT, rlc_pkg::CMD_LOOKUP: begin
                     s1_valid_in = 1'b1;
                     s1_lookup_in = (req_item.cmd == rlc_pkg::CMD_LOOKUP);
                     s1_oor_in = !req_in_range;
                     s1_inc_in = req_item.label_valid;
                     s1_addr_in = ADDR_W'(req_item.label);
                  end
                  rlc_pkg::CMD_RENUMBER: begin
                     state_in = ST_WALK;
                     walk_addr_in = '0;
                     walk_last_in = (highest_ff < LAST_CAP) ? highest_ff : LAST_CAP;
                     next_in = '0;
                  end
                  default: begin
                     state_in = ST_CLEAR;
                     clr_addr_in = '0;
                     clr_rsp_in = 1'b1;
                  end
               endcase
            end
         end
         ST_WALK: begin
            rd_addr = ADDR_W'(walk_addr_ff);
            walk_pend_in = 1'b1;
            walk_rd_addr_in = ADDR_W'(walk_addr_ff);
            walk_addr_in = walk_addr_ff + LW'(1);
            if (walk_addr_ff == walk_last_ff) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_in.new_label = '0;
            rsp_in.distinct_labels = next_hit;
            rsp_in.label_out_of_range = 1'b0;
         end
         default: begin
            wr_en = 1'b1;
            wr_addr = clr_addr_ff;
            wr_data = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == CLEAR_LAST) begin
               state_in = ST_IDLE;
               rsp_valid_in = clr_rsp_ff;
               rsp_in = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         highest_ff <= rlc_pkg::HIGHEST_LABEL_RESET;
         s1_valid_ff <= 1'b0;
         walk_pend_ff <= 1'b0;
         clr_addr_ff <= '0;
         clr_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         highest_ff <= highest_in;
         s1_valid_ff <= s1_valid_in;
         walk_pend_ff <= walk_pend_in;
         clr_addr_ff <= clr_addr_in;
         clr_rsp_ff <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_lookup_ff <= s1_lookup_in;
      s1_oor_ff <= s1_oor_in;
      s1_inc_ff <= s1_inc_in;
      s1_addr_ff <= s1_addr_in;
      walk_addr_ff <= walk_addr_in;
      walk_last_ff <= walk_last_in;
      walk_rd_addr_ff <= walk_rd_addr_in;
      next_ff <= next_in;
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire
